/* src/assert_macros.svh */
// Assertion macros for the checker of the audio DMA block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ADI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that stays armed through reset.
`define ADI_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* src/adi_pkg.sv */
// Shared types, codes and constants of the audio DMA interface.
package adi_pkg;

  // Item kinds on the input channel.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_FETCH = 2'd3;

  // Register indexes.
  localparam logic [2:0] REG_ADDR    = 3'd0;
  localparam logic [2:0] REG_LEN     = 3'd1;
  localparam logic [2:0] REG_CTRL    = 3'd2;
  localparam logic [2:0] REG_STATUS  = 3'd3;
  localparam logic [2:0] REG_DACRATE = 3'd4;
  localparam logic [2:0] REG_BITRATE = 3'd5;

  // Result kinds.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_FETCH  = 2'd2;
  localparam logic [1:0] KIND_SAMPLE = 2'd3;

  localparam int unsigned AW   = 27;
  localparam int unsigned LW   = 18;
  localparam int unsigned FW   = 26;
  localparam int unsigned PW   = 15;
  localparam int unsigned TW   = 16;
  localparam int unsigned DVW  = 36;
  localparam int unsigned DSW  = 26;
  localparam int unsigned CNTW = 6;
  localparam int unsigned YW   = 28;
  localparam int unsigned RW   = 57;
  localparam int unsigned RSH  = 35;

  localparam logic [FW-1:0]  FREQ_RESET  = 26'd48609375;
  localparam logic [DVW-1:0] DAC_CLOCK   = 36'd46875000;
  localparam logic [DVW-1:0] TICK_CLOCK  = 36'd93750000;
  localparam logic [CNTW-1:0] DIV_STEPS  = 6'd36;

  // f * 1037 / 1000 is f + (37 * f / 8) / 125; the divide by 125 is a
  // multiply by the rounded-up reciprocal 2^35 / 125.
  localparam logic [5:0]     SCALE_FRAC  = 6'd37;
  localparam logic [28:0]    RECIP_125   = 29'd274877907;

  typedef enum logic [1:0] {
    DIV_FREQ   = 2'd0,
    DIV_PERIOD = 2'd1
  } div_op_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  reg_index;
    logic [31:0] word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        read_data;
    logic [AW-1:0]      fetch_address;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               buffer_end;
    logic               irq_level;
    logic [FW-1:0]      sample_rate;
  } result_t;

  typedef struct packed {
    logic    div_start;
    div_op_t div_op;
    logic    mul_load;
    logic    scale_load;
    logic    freq_load;
    logic    period_load;
    logic    item_done;
  } dp_cmd_t;

  typedef struct packed {
    logic rate_req;
    logic div_done;
  } dp_stat_t;

endpackage

/* src/adi_ifs.sv */
// Valid/ready channel interfaces for input items and result items.
interface adi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  reg_index;
  logic [31:0] word;

  modport source (output valid, output action, output reg_index, output word, input ready);
  modport sink   (input valid, input action, input reg_index, input word, output ready);
endinterface

interface adi_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [31:0]        read_data;
  logic [26:0]        fetch_address;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               buffer_end;
  logic               irq_level;
  logic [25:0]        sample_rate;

  modport source (output valid, output kind, output read_data, output fetch_address,
                  output left_sample, output right_sample, output buffer_end,
                  output irq_level, output sample_rate, input ready);
  modport sink   (input valid, input kind, input read_data, input fetch_address,
                  input left_sample, input right_sample, input buffer_end,
                  input irq_level, input sample_rate, output ready);
endinterface

/* src/adi_div.sv */
// Restoring divider producing one quotient bit per cycle.
module adi_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [adi_pkg::DVW-1:0]      dividend,
  input  logic [adi_pkg::DSW-1:0]      divisor,
  output logic [adi_pkg::DVW-1:0]      quotient,
  output logic                         done
);

  logic                         busy_r;
  logic                         done_r;
  logic [adi_pkg::CNTW-1:0]     cnt_r;
  logic [adi_pkg::DSW-1:0]      rem_r;
  logic [adi_pkg::DVW-1:0]      quo_r;
  logic [adi_pkg::DSW-1:0]      dsr_r;
  logic [adi_pkg::DSW:0]        trial;
  logic                         ge;
  logic [adi_pkg::DSW:0]        diff;

  assign trial = {rem_r, quo_r[adi_pkg::DVW-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= adi_pkg::DIV_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[adi_pkg::DSW-1:0] : trial[adi_pkg::DSW-1:0];
      quo_r <= {quo_r[adi_pkg::DVW-2:0], ge};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

/* src/adi_ctrl.sv */
// Controller that sequences the DAC rate computation.
module adi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  adi_pkg::dp_stat_t stat,
  output adi_pkg::dp_cmd_t  cmd,
  output logic              idle
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV_F = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_FREQ  = 6'b010000,
    ST_DIV_P = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_op = adi_pkg::DIV_FREQ;
    case (state_r)
      ST_IDLE: begin
        if (stat.rate_req) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = adi_pkg::DIV_FREQ;
          state_nxt     = ST_DIV_F;
        end
      end
      ST_DIV_F: begin
        if (stat.div_done) begin
          cmd.mul_load = 1'b1;
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.scale_load = 1'b1;
        state_nxt      = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.freq_load = 1'b1;
        state_nxt     = ST_FREQ;
      end
      ST_FREQ: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = adi_pkg::DIV_PERIOD;
        state_nxt     = ST_DIV_P;
      end
      ST_DIV_P: begin
        if (stat.div_done) begin
          cmd.period_load = 1'b1;
          cmd.item_done   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = (state_r == ST_IDLE);

endmodule

/* src/adi_dp.sv */
// Datapath: transfer queue, tick counter, rate registers and result buffer.
module adi_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  adi_pkg::in_item_t in_item,
  input  adi_pkg::dp_cmd_t  cmd,
  output adi_pkg::dp_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output adi_pkg::result_t  out_res,
  output logic              room
);

  logic [1:0]              qcnt_r, qcnt_nxt;
  logic [adi_pkg::AW-1:0]  addr_r [2];
  logic [adi_pkg::AW-1:0]  addr_nxt [2];
  logic [adi_pkg::LW-1:0]  len_r [2];
  logic [adi_pkg::LW-1:0]  len_nxt [2];
  logic                    dac_en_r, dac_en_nxt;
  logic [adi_pkg::FW-1:0]  freq_r, freq_nxt;
  logic [adi_pkg::PW-1:0]  period_r, period_nxt;
  logic [adi_pkg::TW-1:0]  tick_r, tick_nxt;
  logic                    pend_r, pend_nxt;
  logic                    irq_r, irq_nxt;
  logic [adi_pkg::YW-1:0]  prod_r;
  logic [31:0]             prod_full;
  logic [adi_pkg::RW-1:0]  recip_r;
  logic [adi_pkg::RW-1:0]  recip_full;

  logic                    rate_req;
  logic                    push;
  adi_pkg::result_t        res;

  logic                    div_start;
  logic [adi_pkg::DVW-1:0] div_dividend;
  logic [adi_pkg::DSW-1:0] div_divisor;
  logic [adi_pkg::DVW-1:0] div_q;
  logic                    div_done;

  logic [adi_pkg::TW-1:0]  tick_inc;
  logic [adi_pkg::LW-1:0]  len_in;
  logic [adi_pkg::LW-1:0]  len_dec;
  logic [1:0]              qcnt_dec;
  logic                    q_full;
  logic                    q_busy;

  logic                    v0_r, v1_r, v0_nxt, v1_nxt, v0_a;
  adi_pkg::result_t        d0_r, d1_r, d0_nxt, d1_nxt, d0_a;
  logic                    pop;

  assign rate_req = in_fire && (in_item.action == adi_pkg::ACT_WRITE)
                    && (in_item.reg_index == adi_pkg::REG_DACRATE);

  always_comb begin
    case (cmd.div_op)
      adi_pkg::DIV_PERIOD: begin
        div_dividend = adi_pkg::TICK_CLOCK;
        div_divisor  = freq_r;
      end
      default: begin
        div_dividend = adi_pkg::DAC_CLOCK;
        div_divisor  = adi_pkg::DSW'({1'b0, in_item.word[13:0]} + 15'd1);
      end
    endcase
  end

  assign div_start = cmd.div_start;

  adi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  // The base frequency stays in the divider's quotient register until the
  // period divide starts, so the scaled sum can pick it up from there.
  assign prod_full  = 32'(div_q[adi_pkg::FW-1:0]) * 32'(adi_pkg::SCALE_FRAC);
  assign recip_full = adi_pkg::RW'(prod_r) * adi_pkg::RW'(adi_pkg::RECIP_125);

  assign stat.rate_req = rate_req;
  assign stat.div_done = div_done;

  assign tick_inc = tick_r + 1'b1;
  assign len_in   = {in_item.word[17:3], 3'b000};
  assign len_dec  = len_r[0] - 18'd4;
  assign qcnt_dec = qcnt_r - 1'b1;
  assign q_full   = (qcnt_r > 2'd1);
  assign q_busy   = (qcnt_r != 2'd0);

  always_comb begin
    qcnt_nxt   = qcnt_r;
    addr_nxt   = addr_r;
    len_nxt    = len_r;
    dac_en_nxt = dac_en_r;
    freq_nxt   = freq_r;
    period_nxt = period_r;
    tick_nxt   = tick_r;
    pend_nxt   = pend_r;
    irq_nxt    = irq_r;
    res        = '0;
    if (in_fire) begin
      case (in_item.action)
        adi_pkg::ACT_WRITE: begin
          case (in_item.reg_index)
            adi_pkg::REG_ADDR: begin
              if (!q_full) begin
                addr_nxt[qcnt_r[0]] = adi_pkg::AW'(in_item.word[23:0]);
              end
            end
            adi_pkg::REG_LEN: begin
              if (!q_full && (len_in != '0)) begin
                len_nxt[qcnt_r[0]] = len_in;
                qcnt_nxt           = qcnt_r + 1'b1;
              end
            end
            adi_pkg::REG_CTRL: begin
              dac_en_nxt = in_item.word[0];
            end
            adi_pkg::REG_STATUS: begin
              irq_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
        adi_pkg::ACT_READ: begin
          res.kind = adi_pkg::KIND_READ;
          case (in_item.reg_index)
            adi_pkg::REG_STATUS: begin
              res.read_data = {q_full, q_busy, 5'b0, 1'b1, 3'b0, 1'b1, 19'b0, q_full};
            end
            adi_pkg::REG_LEN: begin
              res.read_data = 32'(len_r[0]);
            end
            default: begin
            end
          endcase
        end
        adi_pkg::ACT_TICK: begin
          tick_nxt = tick_inc;
          if (tick_inc > {1'b0, period_r}) begin
            tick_nxt = tick_inc - {1'b0, period_r};
            if (q_busy && !pend_r) begin
              res.kind          = adi_pkg::KIND_FETCH;
              res.fetch_address = addr_r[0];
              pend_nxt          = 1'b1;
            end
          end
        end
        default: begin
          if (pend_r && q_busy) begin
            pend_nxt          = 1'b0;
            res.kind          = adi_pkg::KIND_SAMPLE;
            res.left_sample   = {in_item.word[23:16], in_item.word[31:24]};
            res.right_sample  = {in_item.word[7:0], in_item.word[15:8]};
            addr_nxt[0]       = addr_r[0] + 27'd4;
            len_nxt[0]        = len_dec;
            if (len_dec == '0) begin
              irq_nxt        = 1'b1;
              qcnt_nxt       = qcnt_dec;
              res.buffer_end = 1'b1;
              if (qcnt_dec != 2'd0) begin
                addr_nxt[0] = addr_r[1];
                len_nxt[0]  = len_r[1];
              end
            end
          end
        end
      endcase
    end
    if (cmd.freq_load) begin
      freq_nxt = div_q[adi_pkg::FW-1:0]
                 + adi_pkg::FW'(recip_r[adi_pkg::RW-1:adi_pkg::RSH]);
    end
    if (cmd.period_load) begin
      period_nxt = div_q[adi_pkg::PW-1:0];
    end
    res.irq_level   = irq_nxt;
    res.sample_rate = freq_nxt;
  end

  assign push = (in_fire && !rate_req) || cmd.item_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r   <= '0;
      addr_r   <= '{default: '0};
      len_r    <= '{default: '0};
      dac_en_r <= 1'b0;
      freq_r   <= adi_pkg::FREQ_RESET;
      period_r <= 15'd1;
      tick_r   <= '0;
      pend_r   <= 1'b0;
      irq_r    <= 1'b0;
    end else begin
      qcnt_r   <= qcnt_nxt;
      addr_r   <= addr_nxt;
      len_r    <= len_nxt;
      dac_en_r <= dac_en_nxt;
      freq_r   <= freq_nxt;
      period_r <= period_nxt;
      tick_r   <= tick_nxt;
      pend_r   <= pend_nxt;
      irq_r    <= irq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod_r <= prod_full[adi_pkg::YW+2:3];
    end
    if (cmd.scale_load) begin
      recip_r <= recip_full;
    end
  end

  // Two-entry result buffer; slot 0 drives the output channel.
  always_comb begin
    pop    = v0_r && out_ready;
    v0_a   = pop ? v1_r : v0_r;
    d0_a   = pop ? d1_r : d0_r;
    v0_nxt = v0_a;
    v1_nxt = pop ? 1'b0 : v1_r;
    d0_nxt = d0_a;
    d1_nxt = d1_r;
    if (push) begin
      if (!v0_a) begin
        v0_nxt = 1'b1;
        d0_nxt = res;
      end else begin
        v1_nxt = 1'b1;
        d1_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

  assign out_valid = v0_r;
  assign out_res   = d0_r;
  assign room      = !v1_r;

endmodule

/* src/audio_dma_interface_core.sv */
// Top level of the audio DMA interface: controller, datapath and channel wiring.
// The result of a write, read, tick or fetched word is registered into the result buffer on accept.
// Throughput: one such item per cycle, held off while two results wait unread or a rate is computed.
// A DAC rate write runs two 36-step divides and two multiplies before its result is pushed.
// No item is accepted during a DAC rate computation.
// Reset is synchronous and active low; it clears the queue, the interrupt and the result buffer.
module audio_dma_interface_core (
  input  logic       clk,
  input  logic       rst_n,
  adi_in_if.sink     in_ch,
  adi_out_if.source  out_ch
);

  adi_pkg::in_item_t in_item;
  adi_pkg::dp_cmd_t  cmd;
  adi_pkg::dp_stat_t stat;
  adi_pkg::result_t  out_res;
  logic              ctrl_idle;
  logic              room;
  logic              in_fire;
  logic              out_valid;

  // An item is taken only while no rate computation is running and the
  // result buffer has a free slot, so every accepted item has a place for
  // its result.
  assign in_ch.ready = ctrl_idle && room;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign in_item.action    = in_ch.action;
  assign in_item.reg_index = in_ch.reg_index;
  assign in_item.word      = in_ch.word;

  // The controller only steps through the divide and multiply sequence of a
  // DAC rate write; every other item is handled by the datapath in the
  // cycle it is accepted.
  adi_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd),
    .idle  (ctrl_idle)
  );

  adi_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .room      (room)
  );

  // The result channel is driven straight from the head of the buffer.
  assign out_ch.valid         = out_valid;
  assign out_ch.kind          = out_res.kind;
  assign out_ch.read_data     = out_res.read_data;
  assign out_ch.fetch_address = out_res.fetch_address;
  assign out_ch.left_sample   = out_res.left_sample;
  assign out_ch.right_sample  = out_res.right_sample;
  assign out_ch.buffer_end    = out_res.buffer_end;
  assign out_ch.irq_level     = out_res.irq_level;
  assign out_ch.sample_rate   = out_res.sample_rate;

endmodule

/* src/adi_checker.sv */
// Port-level checker for the audio DMA interface and its bind statement.
`include "assert_macros.svh"

module adi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic [31:0]        read_data,
  input logic [26:0]        fetch_address,
  input logic               buffer_end,
  input logic               irq_level
);

  `ADI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(read_data), "stalled result changed")
  `ADI_ASSERT_IMPL(a_addr_zero, out_valid && (kind != adi_pkg::KIND_FETCH), fetch_address == '0, "fetch address outside fetch request")
  `ADI_ASSERT_IMPL(a_bend_irq, out_valid && buffer_end, (kind == adi_pkg::KIND_SAMPLE) && irq_level, "buffer end without sample or interrupt")
  `ADI_ASSERT_IMPL(a_rdata_zero, out_valid && (kind != adi_pkg::KIND_READ), read_data == '0, "read data outside read result")
  `ADI_ASSERT_NEXT_RST(a_reset_empty, !rst_n, !out_valid, "result pending after reset")

endmodule

bind audio_dma_interface_core adi_checker u_adi_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .kind          (out_ch.kind),
  .read_data     (out_ch.read_data),
  .fetch_address (out_ch.fetch_address),
  .buffer_end    (out_ch.buffer_end),
  .irq_level     (out_ch.irq_level)
);

/* sim/audio_dma_interface_core_tb.sv */
// Self-checking testbench for the audio DMA interface core: predicts every result item and checks it.
module audio_dma_interface_core_tb;
  import adi_pkg::*;

  // Stimulus volume and the cycle budget. The slowest legal run is roughly
  // 950 items, each waiting out the longest sender gap, the longest receiver
  // stall and, for DAC rate writes, a full rate computation. The budget
  // is several times that.
  localparam int ITEM_TOTAL  = 950;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 120;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 300;

  // Scoreboard: a cycle-free model of the block plus the queue of results it
  // expects. Every accepted input item yields exactly one result item.
  class audio_dma_scoreboard;
    // Copy of the block state, at the block's own widths.
    logic [1:0]    queued;
    logic [AW-1:0] xfer_addr[2];
    logic [LW-1:0] xfer_len[2];
    logic          dac_on;
    logic [FW-1:0] freq;
    logic [PW-1:0] period;
    logic [TW-1:0] ticks;
    bit            fetch_pending;
    bit            irq;

    result_t awaited_results[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      queued        = '0;
      xfer_addr[0]  = '0;
      xfer_addr[1]  = '0;
      xfer_len[0]   = '0;
      xfer_len[1]   = '0;
      dac_on        = 1'b0;
      freq          = FREQ_RESET;
      period        = 15'd1;
      ticks         = '0;
      fetch_pending = 0;
      irq           = 0;
      errors        = 0;
      checked       = 0;
    endfunction

    function string describe(result_t r);
      return $sformatf("kind=%0d rdata=%h faddr=%h left=%0d right=%0d end=%0d irq=%0d rate=%0d",
                       r.kind, r.read_data, r.fetch_address, r.left_sample, r.right_sample,
                       r.buffer_end, r.irq_level, r.sample_rate);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    // Advances the model by one accepted input item and queues its result.
    function void note_item(in_item_t it);
      result_t         r;
      logic [LW-1:0]   len;
      longint unsigned base_freq;
      longint unsigned scaled;
      logic            full;
      logic            busy;
      r = '0;
      case (it.action)
        ACT_WRITE: begin
          case (it.reg_index)
            REG_ADDR: begin
              if (queued < 2) xfer_addr[queued[0]] = AW'(it.word[23:0]);
            end
            REG_LEN: begin
              len = it.word[LW-1:0] & 18'h3fff8;
              if (queued < 2 && len != '0) begin
                xfer_len[queued[0]] = len;
                queued++;
              end
            end
            REG_CTRL:   dac_on = it.word[0];
            REG_STATUS: irq = 0;
            REG_DACRATE: begin
              // The divider is 36 bits wide, so exact 64-bit math here matches it.
              base_freq = 64'd46875000 / (longint'(it.word[13:0]) + 1);
              scaled    = (base_freq * 1037) / 1000;
              if (scaled == 0) scaled = 1;
              freq   = FW'(scaled);
              period = PW'(64'd93750000 / scaled);
            end
            default: ;
          endcase
        end
        ACT_READ: begin
          r.kind = KIND_READ;
          if (it.reg_index == REG_STATUS) begin
            full = (queued > 1);
            busy = (queued > 0);
            r.read_data     = '0;
            r.read_data[0]  = full;
            r.read_data[20] = 1'b1;
            r.read_data[24] = 1'b1;
            r.read_data[30] = busy;
            r.read_data[31] = full;
          end else if (it.reg_index == REG_LEN) begin
            r.read_data = 32'(xfer_len[0]);
          end
        end
        ACT_TICK: begin
          ticks = ticks + 1'b1;
          if (ticks > TW'(period)) begin
            // Only one sample can become due per tick, however far behind we are.
            ticks = ticks - TW'(period);
            if (queued != 0 && !fetch_pending) begin
              r.kind          = KIND_FETCH;
              r.fetch_address = xfer_addr[0];
              fetch_pending   = 1;
            end
          end
        end
        default: begin
          if (fetch_pending && queued != 0) begin
            fetch_pending  = 0;
            r.kind         = KIND_SAMPLE;
            r.left_sample  = {it.word[23:16], it.word[31:24]};
            r.right_sample = {it.word[7:0], it.word[15:8]};
            xfer_addr[0]   = xfer_addr[0] + 27'd4;
            xfer_len[0]    = xfer_len[0] - 18'd4;
            if (xfer_len[0] == '0) begin
              irq = 1;
              queued--;
              if (queued > 0) begin
                xfer_addr[0] = xfer_addr[1];
                xfer_len[0]  = xfer_len[1];
              end
              r.buffer_end = 1'b1;
            end
          end
        end
      endcase
      r.irq_level   = irq;
      r.sample_rate = freq;
      awaited_results.insert(awaited_results.size(), r);
    endfunction

    // Compares one result item from the block with the oldest expectation.
    function void check_result(result_t got);
      result_t want;
      string   bad;
      if (awaited_results.size() == 0) begin
        flag($sformatf("result with nothing expected: %s", describe(got)));
        return;
      end
      want = awaited_results.pop_front();
      bad  = "";
      if (got.kind !== want.kind)                   bad = {bad, " kind"};
      if (got.read_data !== want.read_data)         bad = {bad, " read_data"};
      if (got.fetch_address !== want.fetch_address) bad = {bad, " fetch_address"};
      if (got.left_sample !== want.left_sample)     bad = {bad, " left_sample"};
      if (got.right_sample !== want.right_sample)   bad = {bad, " right_sample"};
      if (got.buffer_end !== want.buffer_end)       bad = {bad, " buffer_end"};
      if (got.irq_level !== want.irq_level)         bad = {bad, " irq_level"};
      if (got.sample_rate !== want.sample_rate)     bad = {bad, " sample_rate"};
      if (bad != "")
        flag($sformatf("result %0d differs in%s\n  expected %s\n  actual   %s",
                       checked, bad, describe(want), describe(got)));
      checked++;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  adi_in_if  in_ch();
  adi_out_if out_ch();

  audio_dma_interface_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  audio_dma_scoreboard sb = new();

  int unsigned items_sent;
  int unsigned cycles;
  bit          quiet;

  // Every input starts at a known value before the first clock edge.
  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_WRITE;
    in_ch.reg_index = REG_ADDR;
    in_ch.word      = '0;
    out_ch.ready    = 1'b0;
    items_sent      = 0;
    quiet           = 0;
  end

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial cycles = 0;

  // Offers one item from a falling edge and returns at the falling edge after
  // it was accepted. A random gap may come first; when the next item follows
  // at once, valid simply stays high.
  task automatic send_item(input logic [1:0] act, input logic [2:0] ri, input logic [31:0] w);
    in_item_t it;
    it.action    = act;
    it.reg_index = ri;
    it.word      = w;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.reg_index <= ri;
    in_ch.word      <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // A length word with the length field set to the given number of 8-byte
  // units; the bits outside the field stay random.
  function automatic logic [31:0] len_word(input int unsigned units);
    logic [31:0] w;
    w        = $urandom;
    w[17:3]  = 15'(units);
    return w;
  endfunction

  // A DAC rate word. Small rates keep the tick period short so that samples
  // stay frequent; the bits above the rate field are random.
  function automatic logic [31:0] rate_word(input bit wide);
    logic [31:0] w;
    w       = $urandom;
    w[13:0] = wide ? 14'($urandom_range(0, 16383)) : 14'($urandom_range(0, 6));
    return w;
  endfunction

  // Receiver side: random ready bursts, one long hold-off once the block has
  // had time to fill, and a steady ready in the quiet tail of the run.
  initial begin
    int unsigned n;
    bit          held;
    logic        level;
    held = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!held && items_sent >= HOLD_AT) begin
        held  = 1;
        level = 1'b0;
        n     = HOLD_CYCLES;
      end else if (quiet) begin
        level = 1'b1;
        n     = 1;
      end else if ($urandom_range(0, 2) == 0) begin
        level = 1'b0;
        n     = $urandom_range(1, 11);
      end else begin
        level = 1'b1;
        n     = $urandom_range(1, 20);
      end
      out_ch.ready <= level;
      repeat (n) @(negedge clk);
    end
  end

  // Result monitor: every handshake on the result channel is checked.
  always @(posedge clk) begin
    result_t seen;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.kind          = out_ch.kind;
      seen.read_data     = out_ch.read_data;
      seen.fetch_address = out_ch.fetch_address;
      seen.left_sample   = out_ch.left_sample;
      seen.right_sample  = out_ch.right_sample;
      seen.buffer_end    = out_ch.buffer_end;
      seen.irq_level     = out_ch.irq_level;
      seen.sample_rate   = out_ch.sample_rate;
      sb.check_result(seen);
    end
  end

  initial begin
    int unsigned pick;
    logic [2:0]  ri;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Reads straight out of reset see the empty queue.
    send_item(ACT_READ,  REG_STATUS,  32'h0000_0000);
    send_item(ACT_READ,  REG_LEN,     32'hffff_ffff);
    send_item(ACT_READ,  3'd7,        32'h0000_0000);
    // Bitrate and unknown register writes leave the state alone.
    send_item(ACT_WRITE, REG_BITRATE, 32'hffff_ffff);
    send_item(ACT_WRITE, 3'd7,        32'hffff_ffff);
    send_item(ACT_WRITE, REG_CTRL,    32'hffff_ffff);
    // With the reset period of one, the second tick is due with an empty queue.
    send_item(ACT_TICK,  REG_ADDR,    32'h0000_0000);
    send_item(ACT_TICK,  3'd7,        32'hffff_ffff);
    // A memory word that nobody asked for is dropped.
    send_item(ACT_FETCH, REG_ADDR,    32'hffff_ffff);
    // A length of zero after masking does not queue a transfer.
    send_item(ACT_WRITE, REG_LEN,     32'h0000_0007);
    // Fill both queue slots: highest address with 8 bytes, then 16 bytes at zero.
    send_item(ACT_WRITE, REG_ADDR,    32'hffff_ffff);
    send_item(ACT_WRITE, REG_LEN,     32'hfffc_000f);
    send_item(ACT_WRITE, REG_ADDR,    32'h0000_0000);
    send_item(ACT_WRITE, REG_LEN,     32'h0000_0010);
    // Writes to a full queue are ignored; status then reports it full.
    send_item(ACT_WRITE, REG_ADDR,    32'h1234_5678);
    send_item(ACT_WRITE, REG_LEN,     32'h0000_0008);
    send_item(ACT_READ,  REG_STATUS,  32'h0000_0000);
    // First tick requests a word; the next due tick finds the fetch pending
    // and drops its sample.
    send_item(ACT_TICK,  REG_LEN,     32'h0000_0000);
    send_item(ACT_TICK,  REG_LEN,     32'h0000_0000);
    send_item(ACT_FETCH, REG_LEN,     32'h80ff_7f00);
    send_item(ACT_TICK,  REG_LEN,     32'h0000_0000);
    // The second sample ends the first transfer and raises the interrupt.
    send_item(ACT_FETCH, REG_LEN,     32'h7f00_80ff);
    send_item(ACT_WRITE, REG_STATUS,  32'h0000_0000);
    // Slowest DAC rate, then back to the fastest one.
    send_item(ACT_WRITE, REG_DACRATE, 32'hffff_ffff);
    send_item(ACT_WRITE, REG_DACRATE, 32'h0000_0000);

    // Random part. Most items form well-behaved traffic: transfers are
    // queued while there is room, ticks request words and the requested words
    // come back. The rest is reads, noise writes and words nobody asked for.
    while (items_sent < ITEM_TOTAL) begin
      quiet = (items_sent >= ITEM_TOTAL * 17 / 20);
      pick  = $urandom_range(0, 99);
      ri    = 3'($urandom_range(0, 7));
      if (sb.fetch_pending && pick < 50) begin
        send_item(ACT_FETCH, ri, $urandom);
      end else if (sb.queued < 2 && pick < 62) begin
        send_item(ACT_WRITE, REG_ADDR, $urandom);
        send_item(ACT_WRITE, REG_LEN, len_word($urandom_range(1, 12)));
      end else if (pick < 85) begin
        send_item(ACT_TICK, ri, $urandom);
      end else if (pick < 91) begin
        if ($urandom_range(0, 3) != 0) ri = $urandom_range(0, 1) ? REG_STATUS : REG_LEN;
        send_item(ACT_READ, ri, $urandom);
      end else if (pick < 96) begin
        // Noise writes. Lengths stay short or vanish under the mask so that
        // transfers keep ending.
        if (ri == REG_DACRATE)
          send_item(ACT_WRITE, ri, rate_word(0));
        else if (ri == REG_LEN)
          send_item(ACT_WRITE, ri, len_word($urandom_range(0, 2)));
        else
          send_item(ACT_WRITE, ri, $urandom);
      end else if (pick < 98) begin
        send_item(ACT_WRITE, REG_DACRATE, rate_word(0));
      end else if (pick < 99) begin
        // A rate from anywhere in the field, then a fast one again.
        send_item(ACT_WRITE, REG_DACRATE, rate_word(1));
        send_item(ACT_WRITE, REG_DACRATE, rate_word(0));
      end else begin
        send_item(ACT_FETCH, ri, $urandom);
      end
    end
    in_ch.valid <= 1'b0;

    // Drain: every expected item, then room for a late rate result.
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.errors == 0 && sb.awaited_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* audio_dma_interface_core.f */
+incdir+src
src/adi_pkg.sv
src/adi_ifs.sv
src/adi_div.sv
src/adi_ctrl.sv
src/adi_dp.sv
src/audio_dma_interface_core.sv
src/adi_checker.sv
sim/audio_dma_interface_core_tb.sv
